>>> rtl/qpht_pkg.sv
// qpht_pkg: shared types and constants of the quadratic probe hash table
// no dependencies; imported by the interfaces, quadratic_probe_hash_table_top and the bench
`default_nettype none

package qpht_pkg;

  // key width of one slot and of the input beat
  localparam int unsigned KEY_W = 31;
  // width of the reported slot number
  localparam int unsigned SLOT_OUT_W = 4;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

`default_nettype wire

>>> rtl/qpht_if.sv
// qpht_in_if / qpht_out_if: valid-ready channels of the hash table
// depends on qpht_pkg
`default_nettype none

interface qpht_in_if import qpht_pkg::*; ();
  logic             valid;
  logic             ready;
  op_e              op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface qpht_out_if import qpht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_e               status;
  logic [SLOT_OUT_W-1:0] slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

>>> rtl/qpht_modadd.sv
// qpht_modadd: shared modular adder, (a + b + cin) mod MOD for a, b < MOD
// no dependencies; used by quadratic_probe_hash_table_top
`default_nettype none

module qpht_modadd #(
  parameter int unsigned W   = 4,
  parameter int unsigned MOD = 16
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic         cin_i,
  output logic      [W-1:0] res_o
);

  localparam logic [W:0] M = (W+1)'(MOD);

  logic [W:0] sum;
  logic [W:0] red;

  // one add, one compare and subtract; sum stays below twice the modulus
  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i} + {{W{1'b0}}, cin_i};
    red = (sum >= M) ? (sum - M) : sum;
  end

  assign res_o = red[W-1:0];

endmodule

`default_nettype wire

>>> rtl/quadratic_probe_hash_table_top.sv
// quadratic_probe_hash_table_top: open addressing hash table, quadratic probing
// depends on qpht_pkg, qpht_if (qpht_in_if, qpht_out_if) and qpht_modadd
//
//   channel | dir | payload               | beat
//   in_i    | in  | op, key               | valid & ready
//   out_o   | out | status, slot_index    | valid & ready
//
// after reset a clearing pass writes every slot to zero with in_i.ready low.
// an item then goes through S_HOME for the home slot (key mod TABLE_SIZE
// four key bits a cycle by compare and subtract), S_READ then S_CMP per
// probe (slot ram read, then compare), at most TABLE_SIZE probes, and S_FIN
// to load the result. a zero key goes from S_IDLE straight to S_FIN.
// the result register lets the next beat be taken while out_o stalls; a later
// result waits in S_FIN until the held beat is taken.
`default_nettype none

module quadratic_probe_hash_table_top
  import qpht_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qpht_in_if.sink   in_i,
  qpht_out_if.source out_o
);

  localparam int unsigned IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned PW = (IW > SLOT_OUT_W) ? IW : SLOT_OUT_W;
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_SIZE - 1);
  localparam int unsigned KEY_PAD_W = 32;
  localparam logic [2:0]  DIG_LAST  = 3'(KEY_PAD_W / 4 - 1);
  localparam logic [IW+3:0] MOD_X = (IW+4)'(TABLE_SIZE);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HOME  = 6'b000100,
    S_READ  = 6'b001000,
    S_CMP   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [IW:0]      cnt_q, cnt_d;
  logic [2:0]       dig_q, dig_d;
  logic [IW-1:0]    rem_q, rem_d;
  logic [IW-1:0]    slot_q, slot_d;
  logic [IW-1:0]    nxt_q, nxt_d;
  logic [IW-1:0]    odd_q, odd_d;
  op_e              op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  status_e          res_st_q, res_st_d;
  logic [IW-1:0]    res_slot_q, res_slot_d;

  logic                  out_vld_q, out_vld_d;
  status_e               out_st_q, out_st_d;
  logic [SLOT_OUT_W-1:0] out_slot_q, out_slot_d;

  logic [KEY_W-1:0] mem_q [TABLE_SIZE];
  logic [KEY_W-1:0] rd_q;
  logic             we;
  logic [IW-1:0]    wa;
  logic [KEY_W-1:0] wd;

  logic [IW-1:0] ua, ub, ures;
  logic          ucin;
  logic [PW-1:0] slot_ext;

  logic [KEY_PAD_W-1:0] key_pad;
  logic [IW+3:0]        red;

  // shared modular adder
  qpht_modadd #(
    .W   (IW),
    .MOD (TABLE_SIZE)
  ) u_modadd (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (ucin),
    .res_o (ures)
  );

  // operand selection for the shared adder
  always_comb begin
    ua   = '0;
    ub   = '0;
    ucin = 1'b0;
    unique case (state_q)
      S_READ: begin
        ua = slot_q;
        ub = odd_q;
      end
      S_CMP: begin
        ua   = odd_q;
        ub   = IW'(1);
        ucin = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  // home slot step: rem = (16 * rem + key digit) mod TABLE_SIZE
  always_comb begin
    key_pad = KEY_PAD_W'(key_q);
    red     = {rem_q, key_pad[{dig_q, 2'b00} +: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (red >= (MOD_X << k)) begin
        red = red - (MOD_X << k);
      end
    end
  end

  assign slot_ext = PW'(res_slot_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    dig_d      = dig_q;
    rem_d      = rem_q;
    slot_d     = slot_q;
    nxt_d      = nxt_q;
    odd_d      = odd_q;
    op_d       = op_q;
    key_d      = key_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    out_vld_d  = out_vld_q;
    out_st_d   = out_st_q;
    out_slot_d = out_slot_q;
    we         = 1'b0;
    wa         = slot_q;
    wd         = key_q;

    // result register drains independently
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = cnt_q[IW-1:0];
        wd    = '0;
        cnt_d = cnt_q + (IW+1)'(1);
        if (cnt_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          op_d  = in_i.op;
          key_d = in_i.key;
          rem_d = '0;
          dig_d = DIG_LAST;
          if (in_i.key == '0) begin
            res_st_d   = ST_NOT_FOUND;
            res_slot_d = '0;
            state_d    = S_FIN;
          end else begin
            state_d = S_HOME;
          end
        end
      end
      S_HOME: begin
        // one key digit per cycle, most significant first
        rem_d = red[IW-1:0];
        dig_d = dig_q - 3'd1;
        if (dig_q == '0) begin
          slot_d  = red[IW-1:0];
          odd_d   = IW'(1);
          cnt_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        // next probe slot: slot + (2i + 1)
        nxt_d   = ures;
        state_d = S_CMP;
      end
      S_CMP: begin
        odd_d = ures;
        priority if (op_q == OP_INSERT && rd_q == '0) begin
          we         = 1'b1;
          res_st_d   = ST_INSERTED;
          res_slot_d = slot_q;
          state_d    = S_FIN;
        end else if (op_q == OP_SEARCH && rd_q == key_q) begin
          res_st_d   = ST_FOUND;
          res_slot_d = slot_q;
          state_d    = S_FIN;
        end else if (op_q == OP_SEARCH && rd_q == '0) begin
          res_st_d   = ST_NOT_FOUND;
          res_slot_d = '0;
          state_d    = S_FIN;
        end else if (cnt_q == LAST) begin
          res_st_d   = (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          res_slot_d = '0;
          state_d    = S_FIN;
        end else begin
          slot_d  = nxt_q;
          cnt_d   = cnt_q + (IW+1)'(1);
          state_d = S_READ;
        end
      end
      S_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d  = 1'b1;
          out_st_d   = res_st_q;
          out_slot_d = slot_ext[SLOT_OUT_W-1:0];
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dig_q      <= dig_d;
    rem_q      <= rem_d;
    slot_q     <= slot_d;
    nxt_q      <= nxt_d;
    odd_q      <= odd_d;
    op_q       <= op_d;
    key_q      <= key_d;
    res_st_q   <= res_st_d;
    res_slot_q <= res_slot_d;
    out_st_q   <= out_st_d;
    out_slot_q <= out_slot_d;
  end

  // key slot ram, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[slot_q];
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.status     = out_st_q;
  assign out_o.slot_index = out_slot_q;

endmodule

`default_nettype wire

>>> test/tb_quadratic_probe_hash_table_top.sv
`timescale 1ns / 1ps
// tb_quadratic_probe_hash_table_top: self-checking bench for the quadratic probe hash table
// depends on qpht_pkg, qpht_if and quadratic_probe_hash_table_top; every result beat is
// compared against a local copy of the slot table kept in step with each accepted beat
`default_nettype none

module tb_quadratic_probe_hash_table_top;
  import qpht_pkg::*;

  localparam int unsigned TBL_SIZE     = 16;
  localparam int unsigned CLK_PERIOD   = 20;
  // drain wait, sized for the worst item (TBL_SIZE probes) with margin
  localparam int unsigned DRAIN_CYCLES = 10 + 2 * TBL_SIZE + 20;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot_index;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  qpht_in_if  in_if ();
  qpht_out_if out_if ();

  // local image of the key slots, zero meaning empty
  logic [KEY_W-1:0] slot_keys [TBL_SIZE];
  reply_t           expected_replies [$];
  logic [KEY_W-1:0] stored_keys [$];
  bit               idle_en;
  int unsigned      error_count;
  int unsigned      stall_left;

  quadratic_probe_hash_table_top #(
    .TABLE_SIZE (TBL_SIZE)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // hard limit on run length
  initial begin
    #5ms;
    $display("tb_quadratic_probe_hash_table_top failed");
    $finish;
  end

  // apply one operation to the slot image and return the reply it gives
  function automatic reply_t hash_table_step(input op_e op, input logic [KEY_W-1:0] key);
    reply_t      reply;
    int unsigned home;
    int unsigned slot;
    reply.status     = ST_NOT_FOUND;
    reply.slot_index = '0;
    if (key != '0) begin
      home = key % TBL_SIZE;
      if (op == OP_INSERT) reply.status = ST_FULL;
      for (int unsigned i = 0; i < TBL_SIZE; i++) begin
        slot = (home + (i * i) % TBL_SIZE) % TBL_SIZE;
        if (op == OP_INSERT) begin
          if (slot_keys[slot] == '0) begin
            slot_keys[slot]  = key;
            reply.status     = ST_INSERTED;
            reply.slot_index = SLOT_OUT_W'(slot);
            break;
          end
        end else if (slot_keys[slot] == key) begin
          reply.status     = ST_FOUND;
          reply.slot_index = SLOT_OUT_W'(slot);
          break;
        end else if (slot_keys[slot] == '0) begin
          break;
        end
      end
    end
    return reply;
  endfunction

  // nonzero key: small ones crowd the homes, wide ones toggle every bit
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] key;
    if ($urandom_range(0, 1) == 0) key = KEY_W'($urandom_range(1, 255));
    else key = KEY_W'($urandom());
    if (key == '0) key = KEY_W'(1);
    return key;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // send one beat, record its expected reply once it is taken
  task automatic send_op(input op_e op, input logic [KEY_W-1:0] key);
    reply_t reply;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.key   <= key;
    do @(posedge clk_i); while (!in_if.ready);
    reply = hash_table_step(op, key);
    expected_replies.push_back(reply);
    if (op == OP_INSERT && reply.status == ST_INSERTED) stored_keys.push_back(key);
  endtask

  // receiver stalls in random bursts while idling is enabled
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expected reply
  always @(posedge clk_i) begin : reply_check
    reply_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d slot %0d",
                                  out_if.status, out_if.slot_index));
      end else begin
        want = expected_replies.pop_front();
        if (out_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %s", out_if.status, want.status.name()));
        if (out_if.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot %0d, want %0d", out_if.slot_index, want.slot_index));
      end
    end
  end

  // empty-table miss, plain insert and hit, zero key, widest key, a high-bit insert and a miss
  task automatic test_basic_ops();
    send_op(OP_SEARCH, 31'd5);
    send_op(OP_INSERT, 31'd5);
    send_op(OP_SEARCH, 31'd5);
    send_op(OP_INSERT, 31'd0);
    send_op(OP_SEARCH, 31'd0);
    send_op(OP_INSERT, 31'h7FFF_FFFF);
    send_op(OP_SEARCH, 31'h7FFF_FFFF);
    send_op(OP_INSERT, 31'h4000_0000);
    send_op(OP_SEARCH, 31'h2AAA_AAAA);
  endtask

  // same key twice lands in a second slot, search returns the first copy
  task automatic test_duplicate_insert();
    send_op(OP_INSERT, 31'd24);
    send_op(OP_INSERT, 31'd24);
    send_op(OP_SEARCH, 31'd24);
  endtask

  // fill every slot reachable from one home, then overflow, miss on the full path and hit its last slot
  task automatic test_full_probe_path();
    send_op(OP_INSERT, 31'd2);
    send_op(OP_INSERT, 31'd18);
    send_op(OP_INSERT, 31'd34);
    send_op(OP_INSERT, 31'd50);
    send_op(OP_INSERT, 31'd66);
    send_op(OP_SEARCH, 31'd82);
    send_op(OP_SEARCH, 31'd50);
  endtask

  // mix of fresh inserts, repeated inserts, hits, misses and zero keys
  task automatic test_random_traffic(input int unsigned n_items);
    op_e              op;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op  = OP_INSERT;
        key = random_key();
      end else if (pick < 70 && stored_keys.size() != 0) begin
        op  = (pick < 38) ? OP_INSERT : OP_SEARCH;
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (pick < 95) begin
        op  = OP_SEARCH;
        key = random_key();
      end else begin
        op  = op_e'($urandom_range(0, 1));
        key = '0;
      end
      send_op(op, key);
    end
  endtask

  // main sequence
  initial begin
    foreach (slot_keys[i]) slot_keys[i] = '0;
    idle_en     = 1'b1;
    error_count = 0;
    stall_left  = 0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.op     <= OP_INSERT;
    in_if.key    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_duplicate_insert();
    test_full_probe_path();
    test_random_traffic(500);
    // back to back, no idling on either side
    idle_en = 1'b0;
    test_random_traffic(150);
    in_if.valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_quadratic_probe_hash_table_top passed");
    end else begin
      $display("tb_quadratic_probe_hash_table_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/qpht_pkg.sv
rtl/qpht_if.sv
rtl/qpht_modadd.sv
rtl/quadratic_probe_hash_table_top.sv
test/tb_quadratic_probe_hash_table_top.sv
